// ===== rtl/tfct_pkg.sv =====
// ============================================================================
// tfct_pkg: shared types and constants for the top-k flow count table
// Transfer payloads, request codes, sequencer states and scan status flags.
// ============================================================================
package tfct_pkg;

   // Default sizing of the table
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_KEY_WIDTH   = 64;
   localparam int DEF_COUNT_WIDTH = 32;

   // Fixed field widths on the channels
   localparam int REQ_W   = 2;
   localparam int KEY_W   = 64;
   localparam int VAL_W   = 32;
   localparam int OCC_W   = 7;
   localparam int CAP_W   = 7;
   localparam int STAMP_W = 32;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic             accepted;
      logic             evicted;
      logic [KEY_W-1:0] evicted_key;
      logic [VAL_W-1:0] new_count;
      logic [OCC_W-1:0] occupancy;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // What the scan found over the whole table
   typedef struct packed {
      logic hit;
      logic free_found;
      logic min_found;
   } scan_flags_type;

endpackage

// ===== rtl/topk_flow_count_table_top.sv =====
// ============================================================================
// topk_flow_count_table_top: top-k flow count table
// Keeps up to capacity (key, count) entries; adds, raises and erases counts
// and evicts the oldest least-count entry when a new key with a larger count needs room.
// ============================================================================
//
//   channel | ports                        | direction | payload
//   --------+------------------------------+-----------+------------------
//   request | req_valid req_ready req_data | in        | req_item_type
//   result  | rsp_valid rsp_ready rsp_data | out       | rsp_item_type
//   config  | csr_valid csr_ready csr_data | in        | capacity, 7 bits
//
// Each request is scanned with one RAM read per entry through the single
// compare unit, then passes a drain and a finish state in which at most one
// table write is made and the result is registered. The block takes no new
// request until it has returned to idle after the finish state.
// After reset a clearing pass writes zero to every entry and empties the
// table; no request is taken meanwhile, the config port is always ready.
// A held result does not block the next request; only the finish cycle waits
// for the result register to be free.
//
module topk_flow_count_table_top #(
   parameter int MAX_ENTRIES = tfct_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_WIDTH   = tfct_pkg::DEF_KEY_WIDTH,
   parameter int COUNT_WIDTH = tfct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tfct_pkg::req_item_type      req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output tfct_pkg::rsp_item_type      rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [tfct_pkg::CAP_W-1:0]  csr_data
);

   localparam int IDXW   = $clog2(MAX_ENTRIES);
   localparam int TOTW   = $clog2(MAX_ENTRIES + 1);
   localparam int SW     = tfct_pkg::STAMP_W;
   localparam int CAPW   = tfct_pkg::CAP_W;
   localparam int CMPW   = (TOTW > CAPW) ? TOTW : CAPW;
   localparam int VALW   = tfct_pkg::VAL_W;
   localparam int KEYPW  = tfct_pkg::KEY_W;
   localparam int OCCW   = tfct_pkg::OCC_W;
   localparam int VW     = (COUNT_WIDTH > VALW) ? COUNT_WIDTH : VALW;
   localparam int WORD_W = 1 + KEY_WIDTH + COUNT_WIDTH + SW;

   localparam logic [IDXW-1:0]        LAST_IDX  = IDXW'(MAX_ENTRIES - 1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Registers
   tfct_pkg::state_type        state_ff, state_in;
   logic [IDXW-1:0]            addr_ff, addr_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [IDXW-1:0]            rd_idx_ff;
   tfct_pkg::req_item_type     req_ff, req_in;
   logic [TOTW-1:0]            total_ff, total_in;
   logic [SW-1:0]              stamp_ff, stamp_in;
   logic [CAPW-1:0]            cap_ff, cap_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tfct_pkg::rsp_item_type     rsp_ff, rsp_in;

   // RAM and scan wiring
   logic                       wr_en;
   logic [IDXW-1:0]            wr_addr;
   logic [WORD_W-1:0]          wr_data;
   logic [WORD_W-1:0]          rd_word;
   logic                       scan_clear;
   tfct_pkg::scan_flags_type   flags;
   logic [IDXW-1:0]            hit_idx, free_idx, min_idx;
   logic [COUNT_WIDTH-1:0]     hit_count, min_count;
   logic [KEY_WIDTH-1:0]       min_key;

   // Request decode
   logic [KEY_WIDTH-1:0]       key_m;
   logic [VW-1:0]              value_ext;
   logic [COUNT_WIDTH-1:0]     val_sat;
   logic [COUNT_WIDTH:0]       add_sum;
   logic [COUNT_WIDTH-1:0]     add_cnt;
   logic [CMPW-1:0]            cap_ext, cap_eff;
   logic                       full;

   tfct_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   tfct_scan #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .ent_vld   (rd_vld_ff),
      .ent_idx   (rd_idx_ff),
      .ent_used  (rd_word[WORD_W-1]),
      .ent_key   (rd_word[WORD_W-2 -: KEY_WIDTH]),
      .ent_count (rd_word[SW+COUNT_WIDTH-1 -: COUNT_WIDTH]),
      .ent_stamp (rd_word[SW-1:0]),
      .req_key   (key_m),
      .flags     (flags),
      .hit_idx   (hit_idx),
      .hit_count (hit_count),
      .free_idx  (free_idx),
      .min_idx   (min_idx),
      .min_count (min_count),
      .min_key   (min_key)
   );

   // Key masking, value saturation, saturating add and the full test
   always_comb begin
      key_m     = req_ff.key[KEY_WIDTH-1:0];
      value_ext = VW'(req_ff.value);
      val_sat   = (value_ext > VW'(COUNT_MAX)) ? COUNT_MAX : COUNT_WIDTH'(value_ext);
      add_sum   = {1'b0, hit_count} + {1'b0, val_sat};
      add_cnt   = add_sum[COUNT_WIDTH] ? COUNT_MAX : add_sum[COUNT_WIDTH-1:0];
      cap_ext   = CMPW'(cap_ff);
      if (cap_ff == '0) begin
         cap_eff = CMPW'(1);
      end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
         cap_eff = CMPW'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
      full = CMPW'(total_ff) >= cap_eff;
   end

   // Sequencer: clear pass, scan, finish
   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_vld_in    = 1'b0;
      req_in       = req_ff;
      total_in     = total_ff;
      stamp_in     = stamp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      scan_clear   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;

      case (state_ff)
         tfct_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = tfct_pkg::ST_IDLE;
            end else begin
               addr_in = addr_ff + IDXW'(1);
            end
         end
         tfct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in     = req_data;
               scan_clear = 1'b1;
               addr_in    = '0;
               state_in   = tfct_pkg::ST_SCAN;
            end
         end
         tfct_pkg::ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = tfct_pkg::ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDXW'(1);
            end
         end
         tfct_pkg::ST_DRAIN: begin
            state_in = tfct_pkg::ST_FINISH;
         end
         tfct_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = tfct_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               // A present key reports its count unless changed below
               if (flags.hit) begin
                  rsp_in.new_count = VALW'(hit_count);
               end
               if ((req_ff.req_type == tfct_pkg::REQ_ADD) ||
                   (req_ff.req_type == tfct_pkg::REQ_UPDATE)) begin
                  if (flags.hit) begin
                     if (req_ff.req_type == tfct_pkg::REQ_ADD) begin
                        wr_en            = 1'b1;
                        wr_addr          = hit_idx;
                        wr_data          = {1'b1, key_m, add_cnt, stamp_ff};
                        stamp_in         = stamp_ff + SW'(1);
                        rsp_in.accepted  = 1'b1;
                        rsp_in.new_count = VALW'(add_cnt);
                     end else if (hit_count < val_sat) begin
                        wr_en            = 1'b1;
                        wr_addr          = hit_idx;
                        wr_data          = {1'b1, key_m, val_sat, stamp_ff};
                        stamp_in         = stamp_ff + SW'(1);
                        rsp_in.accepted  = 1'b1;
                        rsp_in.new_count = VALW'(val_sat);
                     end
                  end else if (val_sat != '0) begin
                     // New key: evict the oldest minimum or take a free slot
                     if (full) begin
                        if (flags.min_found && (min_count < val_sat)) begin
                           wr_en              = 1'b1;
                           wr_addr            = min_idx;
                           wr_data            = {1'b1, key_m, val_sat, stamp_ff};
                           stamp_in           = stamp_ff + SW'(1);
                           rsp_in.accepted    = 1'b1;
                           rsp_in.evicted     = 1'b1;
                           rsp_in.evicted_key = KEYPW'(min_key);
                           rsp_in.new_count   = VALW'(val_sat);
                        end
                     end else if (flags.free_found) begin
                        wr_en            = 1'b1;
                        wr_addr          = free_idx;
                        wr_data          = {1'b1, key_m, val_sat, stamp_ff};
                        stamp_in         = stamp_ff + SW'(1);
                        total_in         = total_ff + TOTW'(1);
                        rsp_in.accepted  = 1'b1;
                        rsp_in.new_count = VALW'(val_sat);
                     end
                  end
               end else if (req_ff.req_type == tfct_pkg::REQ_ERASE) begin
                  rsp_in.new_count = '0;
                  if (flags.hit) begin
                     wr_en           = 1'b1;
                     wr_addr         = hit_idx;
                     wr_data         = '0;
                     total_in        = total_ff - TOTW'(1);
                     rsp_in.accepted = 1'b1;
                  end
               end
               rsp_in.occupancy = OCCW'(total_in);
            end
         end
         default: begin
            state_in = tfct_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfct_pkg::ST_CLEAR;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         total_ff     <= '0;
         stamp_ff     <= '0;
         cap_ff       <= tfct_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         total_ff     <= total_in;
         stamp_ff     <= stamp_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
   end

   // Capacity register, written on a csr transfer
   assign csr_ready = 1'b1;
   assign cap_in    = csr_valid ? csr_data : cap_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/tfct_ram.sv =====
// ============================================================================
// tfct_ram: single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module tfct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tfct_scan.sv =====
// ============================================================================
// tfct_scan: per-entry compare unit for the table scan
// Takes one entry a cycle and keeps the key hit, lowest free slot and the
// oldest least-count entry seen so far.
// ============================================================================
module tfct_scan #(
   parameter int MAX_ENTRIES = tfct_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_WIDTH   = tfct_pkg::DEF_KEY_WIDTH,
   parameter int COUNT_WIDTH = tfct_pkg::DEF_COUNT_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           clear,
   input  logic                           ent_vld,
   input  logic [$clog2(MAX_ENTRIES)-1:0] ent_idx,
   input  logic                           ent_used,
   input  logic [KEY_WIDTH-1:0]           ent_key,
   input  logic [COUNT_WIDTH-1:0]         ent_count,
   input  logic [tfct_pkg::STAMP_W-1:0]   ent_stamp,
   input  logic [KEY_WIDTH-1:0]           req_key,
   output tfct_pkg::scan_flags_type       flags,
   output logic [$clog2(MAX_ENTRIES)-1:0] hit_idx,
   output logic [COUNT_WIDTH-1:0]         hit_count,
   output logic [$clog2(MAX_ENTRIES)-1:0] free_idx,
   output logic [$clog2(MAX_ENTRIES)-1:0] min_idx,
   output logic [COUNT_WIDTH-1:0]         min_count,
   output logic [KEY_WIDTH-1:0]           min_key
);

   localparam int IDXW = $clog2(MAX_ENTRIES);

   tfct_pkg::scan_flags_type         flags_ff, flags_in;
   logic [IDXW-1:0]                  hit_idx_ff, free_idx_ff, min_idx_ff;
   logic [COUNT_WIDTH-1:0]           hit_count_ff, min_count_ff;
   logic [KEY_WIDTH-1:0]             min_key_ff;
   logic [tfct_pkg::STAMP_W-1:0]     min_stamp_ff;
   logic                             take_hit, take_free, take_min;

   // Compare the incoming entry against the best so far
   always_comb begin
      take_hit  = ent_vld && ent_used && (ent_key == req_key) && !flags_ff.hit;
      take_free = ent_vld && !ent_used && !flags_ff.free_found;
      take_min  = ent_vld && ent_used &&
                  (!flags_ff.min_found || (ent_count < min_count_ff) ||
                   ((ent_count == min_count_ff) && (ent_stamp < min_stamp_ff)));
      flags_in = flags_ff;
      if (clear) begin
         flags_in = '0;
      end else begin
         if (take_hit) begin
            flags_in.hit = 1'b1;
         end
         if (take_free) begin
            flags_in.free_found = 1'b1;
         end
         if (take_min) begin
            flags_in.min_found = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // Captured entry data; only read when the matching flag is set
   always_ff @(posedge clock) begin
      if (take_hit) begin
         hit_idx_ff   <= ent_idx;
         hit_count_ff <= ent_count;
      end
      if (take_free) begin
         free_idx_ff <= ent_idx;
      end
      if (take_min) begin
         min_idx_ff   <= ent_idx;
         min_count_ff <= ent_count;
         min_stamp_ff <= ent_stamp;
         min_key_ff   <= ent_key;
      end
   end

   assign flags     = flags_ff;
   assign hit_idx   = hit_idx_ff;
   assign hit_count = hit_count_ff;
   assign free_idx  = free_idx_ff;
   assign min_idx   = min_idx_ff;
   assign min_count = min_count_ff;
   assign min_key   = min_key_ff;

endmodule
